// ----- sv/lfmor_pkg.sv -----
// Shared types, constants and trig table builder for the footprint mask / obstacle range unit.
`default_nettype none
package lfmor_pkg;

  // Sizing
  localparam int unsigned MAX_SAMPLES    = 1024;
  localparam int unsigned TRIG_FRAC_BITS = 15;
  localparam int unsigned IDX_W          = $clog2(MAX_SAMPLES);
  localparam int unsigned LEN_W          = IDX_W + 1;
  localparam int unsigned ROM_DEPTH      = MAX_SAMPLES / 2 + 1;
  localparam int unsigned D_W            = $clog2(ROM_DEPTH);
  localparam int unsigned WORD_W         = TRIG_FRAC_BITS + 2;
  localparam int unsigned LD_W           = 15;
  localparam int unsigned DIST_W         = 15;
  localparam int unsigned PROD_W         = LD_W + 1 + WORD_W;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);

  // Range constants in mm
  localparam int unsigned FULL_MM      = 25000;
  localparam int unsigned NEAR_MM      = 50;
  localparam int unsigned NONE_MM      = 26000;
  localparam int unsigned LASER_OFS_MM = 30;
  localparam int unsigned MIN_LEN      = 2;

  // Angle arithmetic for table build, units of 2^-28 rad
  localparam int unsigned        ANG_FRAC     = 28;
  localparam longint unsigned    STEP_ANGLE_Q = 64'd1546081;
  localparam longint unsigned    HALF_PI_Q    = 64'd421657428;
  localparam longint unsigned    FULL_TURN_Q  = 64'd4 * HALF_PI_Q;

  // Configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 14;

  localparam logic [CFG_AW-1:0] REG_SCAN_LENGTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FP_HALFWIDTH  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_FP_FRONT      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FP_CORNER     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CORR_HALFWIDTH = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BOX_DEPTH     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_BOX_CORNER    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SIDE_LIMIT    = 3'd7;

  typedef struct packed {
    logic [10:0] scan_length;
    logic [11:0] footprint_halfwidth_mm;
    logic [11:0] footprint_front_mm;
    logic [9:0]  footprint_corner_offset;
    logic [11:0] corridor_halfwidth_mm;
    logic [13:0] box_depth_mm;
    logic [9:0]  box_corner_offset;
    logic [9:0]  side_limit_offset;
  } cfg_t;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        range_invalid;
  } in_t;

  typedef struct packed {
    logic [14:0]        filtered_range_mm;
    logic               scan_end;
    logic signed [15:0] obstacle_dist_mm;
    logic               obstacle_found;
  } out_t;

  typedef enum logic [1:0] {
    ZONE_NONE,
    ZONE_BOX,
    ZONE_CORR
  } zone_e;

  // Classified sample handed from front to back
  typedef struct packed {
    logic [LD_W-1:0] ld;
    logic            ok;
    logic            last;
    logic            fp_side;
    zone_e           zone;
    logic [D_W-1:0]  d;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] s;
    logic signed [WORD_W-1:0] c;
  } trig_t;

  // shift-and-subtract division, used only while building the table
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned taylor(longint unsigned r, bit odd);
    longint unsigned term;
    longint unsigned k;
    longint          sum;
    bit              neg;
    bit              done;
    term = odd ? r : (64'd1 << ANG_FRAC);
    sum  = longint'(term);
    k    = odd ? 64'd1 : 64'd0;
    neg  = 1'b1;
    done = 1'b0;
    for (int n = 0; n < 40; n++) begin
      if (!done) begin
        term = ((term * r) >> ANG_FRAC) * r >> ANG_FRAC;
        term = udiv(term, (k + 64'd1) * (k + 64'd2));
        k    = k + 64'd2;
        if (term == 64'd0) begin
          done = 1'b1;
        end else begin
          sum = neg ? sum - longint'(term) : sum + longint'(term);
          neg = !neg;
        end
      end
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic longint unsigned to_word(longint unsigned v);
    return (v + (64'd1 << (ANG_FRAC - TRIG_FRAC_BITS - 1))) >> (ANG_FRAC - TRIG_FRAC_BITS);
  endfunction

  // sin/cos words for one offset from the centre
  function automatic trig_t trig_entry(int unsigned i);
    trig_t                    ent;
    longint unsigned          q;
    longint unsigned          r;
    logic signed [WORD_W-1:0] s0;
    logic signed [WORD_W-1:0] c0;
    r = 64'(i) * STEP_ANGLE_Q;
    while (r >= FULL_TURN_Q) begin
      r = r - FULL_TURN_Q;
    end
    q = 64'd0;
    while (r >= HALF_PI_Q && q < 64'd3) begin
      r = r - HALF_PI_Q;
      q = q + 64'd1;
    end
    s0 = WORD_W'(to_word(taylor(r, 1'b1)));
    c0 = WORD_W'(to_word(taylor(r, 1'b0)));
    unique case (q)
      64'd0: begin
        ent.s = s0;
        ent.c = c0;
      end
      64'd1: begin
        ent.s = c0;
        ent.c = -s0;
      end
      64'd2: begin
        ent.s = -s0;
        ent.c = -c0;
      end
      default: begin
        ent.s = -c0;
        ent.c = s0;
      end
    endcase
    return ent;
  endfunction

endpackage
`default_nettype wire

// ----- sv/lidar_footprint_mask_obstacle_range_unit.sv -----
// Throughput: one sample per cycle unless out_ready_i holds the output; the back pipeline
// has four stages (table read, multiply, limit test, running minimum), and a 4-beat queue
// decouples input from output.
// Reset (rst_ni, async, active low): sample counter, running minimum and all valid
// flags clear; configuration registers return to their defaults. No clearing pass.
`default_nettype none
module lidar_footprint_mask_obstacle_range_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lfmor_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  wire logic [lfmor_pkg::CFG_DW-1:0]    cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lfmor_pkg::in_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lfmor_pkg::out_t                      out_data_o
);

  lfmor_pkg::cfg_t  cfg_q;
  lfmor_pkg::item_t front_item, head_item;
  logic             push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_length             <= 11'd1000;
      cfg_q.footprint_halfwidth_mm  <= 12'd450;
      cfg_q.footprint_front_mm      <= 12'd270;
      cfg_q.footprint_corner_offset <= 10'd178;
      cfg_q.corridor_halfwidth_mm   <= 12'd450;
      cfg_q.box_depth_mm            <= 14'd2270;
      cfg_q.box_corner_offset       <= 10'd34;
      cfg_q.side_limit_offset       <= 10'd179;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lfmor_pkg::REG_SCAN_LENGTH:    cfg_q.scan_length <= cfg_wdata_i[10:0];
        lfmor_pkg::REG_FP_HALFWIDTH:   cfg_q.footprint_halfwidth_mm <= cfg_wdata_i[11:0];
        lfmor_pkg::REG_FP_FRONT:       cfg_q.footprint_front_mm <= cfg_wdata_i[11:0];
        lfmor_pkg::REG_FP_CORNER:      cfg_q.footprint_corner_offset <= cfg_wdata_i[9:0];
        lfmor_pkg::REG_CORR_HALFWIDTH: cfg_q.corridor_halfwidth_mm <= cfg_wdata_i[11:0];
        lfmor_pkg::REG_BOX_DEPTH:      cfg_q.box_depth_mm <= cfg_wdata_i[13:0];
        lfmor_pkg::REG_BOX_CORNER:     cfg_q.box_corner_offset <= cfg_wdata_i[9:0];
        lfmor_pkg::REG_SIDE_LIMIT:     cfg_q.side_limit_offset <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  lfmor_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  lfmor_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_item)
  );

  lfmor_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .head_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- sv/lfmor_front.sv -----
// Front end: sample counter, range clamp, footprint rule and obstacle zone selection.
`default_nettype none
module lfmor_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lfmor_pkg::cfg_t  cfg_i,
  input  wire logic             in_valid_i,
  input  wire lfmor_pkg::in_t   in_data_i,
  output logic                  in_ready_o,
  input  wire logic             full_i,
  output logic                  push_o,
  output lfmor_pkg::item_t      item_o
);

  logic [lfmor_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [lfmor_pkg::IDX_W-1:0] idx, len_m1, cen, d_ofs;
  logic [lfmor_pkg::LEN_W-1:0] len;
  logic [31:0]                 len_w;
  logic                        ok, last, fp_side;
  lfmor_pkg::zone_e            zone;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    len_w = 32'(cfg_i.scan_length);
    if (len_w < lfmor_pkg::MIN_LEN) begin
      len_w = lfmor_pkg::MIN_LEN;
    end else if (len_w > lfmor_pkg::MAX_SAMPLES) begin
      len_w = lfmor_pkg::MAX_SAMPLES;
    end
    len    = lfmor_pkg::LEN_W'(len_w);
    len_m1 = lfmor_pkg::IDX_W'(len - lfmor_pkg::LEN_W'(1));
    cen    = lfmor_pkg::IDX_W'(len >> 1);
    // index past the end (length lowered mid-scan) counts as the last sample
    idx    = (idx_q > len_m1) ? len_m1 : idx_q;
    d_ofs  = (idx >= cen) ? idx - cen : cen - idx;
    last   = (idx >= len_m1);

    ok = !in_data_i.range_invalid
         && (32'(in_data_i.range_mm) >= lfmor_pkg::NEAR_MM)
         && (32'(in_data_i.range_mm) <= lfmor_pkg::FULL_MM);

    // centre sample belongs to the left side for the footprint
    if (idx < cen) begin
      fp_side = 32'(d_ofs) > 32'(cfg_i.footprint_corner_offset);
    end else begin
      fp_side = 32'(d_ofs) >= 32'(cfg_i.footprint_corner_offset);
    end

    // ... and to the right side for obstacle zones
    zone = lfmor_pkg::ZONE_NONE;
    if (idx <= cen) begin
      if (32'(d_ofs) >= 32'(cfg_i.box_corner_offset)
          && 32'(d_ofs) <= 32'(cfg_i.side_limit_offset)) begin
        zone = lfmor_pkg::ZONE_CORR;
      end else if (32'(d_ofs) < 32'(cfg_i.box_corner_offset)) begin
        zone = lfmor_pkg::ZONE_BOX;
      end
    end else begin
      if (32'(d_ofs) <= 32'(cfg_i.box_corner_offset)) begin
        zone = lfmor_pkg::ZONE_BOX;
      end else if (32'(d_ofs) <= 32'(cfg_i.side_limit_offset)) begin
        zone = lfmor_pkg::ZONE_CORR;
      end
    end

    item_o.ld      = ok ? lfmor_pkg::LD_W'(in_data_i.range_mm)
                        : lfmor_pkg::LD_W'(lfmor_pkg::FULL_MM);
    item_o.ok      = ok;
    item_o.last    = last;
    item_o.fp_side = fp_side;
    item_o.zone    = zone;
    item_o.d       = lfmor_pkg::D_W'(d_ofs);

    idx_d = last ? '0 : lfmor_pkg::IDX_W'(idx + lfmor_pkg::IDX_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (push_o) begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lfmor_queue.sv -----
// Short queue of classified samples between front and back.
`default_nettype none
module lfmor_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lfmor_pkg::item_t  data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output lfmor_pkg::item_t       data_o
);

  lfmor_pkg::item_t                mem_q [lfmor_pkg::QUEUE_DEPTH];
  logic [lfmor_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [lfmor_pkg::QUEUE_AW:0]    count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == (lfmor_pkg::QUEUE_AW + 1)'(lfmor_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lfmor_back.sv -----
// Back end: trig lookup, projections, limit tests, running minimum and result register.
`default_nettype none
module lfmor_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lfmor_pkg::cfg_t   cfg_i,
  input  wire logic              empty_i,
  input  wire lfmor_pkg::item_t  head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lfmor_pkg::out_t        out_data_o
);

  localparam int unsigned PW = lfmor_pkg::PROD_W;

  // constant sin/cos table, one entry per offset from the centre
  lfmor_pkg::trig_t        trig_rom [lfmor_pkg::ROM_DEPTH];
  // stage A: table read
  logic                    a_vld_q;
  lfmor_pkg::item_t        a_q;
  lfmor_pkg::trig_t        rom_q;
  // stage M: products
  logic                    m_vld_q;
  lfmor_pkg::item_t        m_q;
  logic signed [PW-1:0]    ps_q, pc_q;
  // stage H: tests
  logic                    h_vld_q;
  logic [lfmor_pkg::LD_W-1:0]   h_filt_q;
  logic                         h_last_q, h_hit_q;
  logic [lfmor_pkg::DIST_W-1:0] h_tod_q;
  // running minimum and result
  logic                         nv_q, nv_d;
  logic [lfmor_pkg::DIST_W-1:0] nd_q, nd_d;
  logic                         out_vld_q;
  lfmor_pkg::out_t              out_q, out_d;

  logic                         advance;
  logic                         in_fp, hit;
  logic [lfmor_pkg::LD_W-1:0]   filt;
  logic [lfmor_pkg::DIST_W-1:0] tod, nd_new;
  logic                         nv_new;

  for (genvar g = 0; g < lfmor_pkg::ROM_DEPTH; g++) begin : g_rom
    localparam lfmor_pkg::trig_t ENTRY = lfmor_pkg::trig_entry(g);
    assign trig_rom[g] = ENTRY;
  end

  // ld is at least 50, so a non-negative product means a non-negative trig word
  function automatic logic under(logic signed [PW-1:0] p, logic [13:0] lim);
    logic [PW-2:0] lim_s;
    lim_s = (PW - 1)'(lim) << lfmor_pkg::TRIG_FRAC_BITS;
    return !p[PW-1] && (p[PW-2:0] < lim_s);
  endfunction

  assign advance     = !out_vld_q || out_ready_i;
  assign pop_o       = advance && !empty_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    in_fp = m_q.fp_side ? under(ps_q, 14'(cfg_i.footprint_halfwidth_mm))
                        : under(pc_q, 14'(cfg_i.footprint_front_mm));
    filt  = (m_q.ok && in_fp) ? lfmor_pkg::LD_W'(lfmor_pkg::FULL_MM) : m_q.ld;
    unique case (m_q.zone)
      lfmor_pkg::ZONE_BOX:  hit = under(pc_q, cfg_i.box_depth_mm);
      lfmor_pkg::ZONE_CORR: hit = under(ps_q, 14'(cfg_i.corridor_halfwidth_mm));
      default:              hit = 1'b0;
    endcase
    // negative forward projection clamps to zero
    tod = pc_q[PW-1] ? '0 : pc_q[lfmor_pkg::TRIG_FRAC_BITS +: lfmor_pkg::DIST_W];
  end

  always_comb begin
    nv_new = nv_q || h_hit_q;
    nd_new = (h_hit_q && (!nv_q || (h_tod_q < nd_q))) ? h_tod_q : nd_q;
    out_d.filtered_range_mm = h_filt_q;
    out_d.scan_end          = h_last_q;
    out_d.obstacle_dist_mm  = '0;
    out_d.obstacle_found    = 1'b0;
    nv_d = nv_new;
    nd_d = nd_new;
    if (h_last_q) begin
      out_d.obstacle_dist_mm = nv_new
          ? $signed({1'b0, nd_new}) - 16'(lfmor_pkg::LASER_OFS_MM)
          : 16'(lfmor_pkg::NONE_MM);
      out_d.obstacle_found = nv_new;
      nv_d = 1'b0;
      nd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      nv_q      <= 1'b0;
      nd_q      <= '0;
    end else if (advance) begin
      a_vld_q   <= !empty_i;
      m_vld_q   <= a_vld_q;
      h_vld_q   <= m_vld_q;
      out_vld_q <= h_vld_q;
      if (h_vld_q) begin
        nv_q <= nv_d;
        nd_q <= nd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_q      <= head_i;
      rom_q    <= trig_rom[head_i.d];
      m_q      <= a_q;
      ps_q     <= PW'($signed({1'b0, a_q.ld})) * PW'(rom_q.s);
      pc_q     <= PW'($signed({1'b0, a_q.ld})) * PW'(rom_q.c);
      h_filt_q <= filt;
      h_last_q <= m_q.last;
      h_hit_q  <= hit;
      h_tod_q  <= tod;
      out_q    <= out_d;
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the lidar footprint mask and obstacle range unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_RANDOM = 0;
  localparam int IDLE_NONE   = 1;
  localparam int IDLE_SOME   = 2;

  // Tracks the expected result beat for every accepted sample.
  class scan_scoreboard;
    lfmor_pkg::cfg_t  regs;
    int unsigned      sample_pos;
    int unsigned      nearest_mm;
    bit               nearest_seen;
    longint           sin_w[lfmor_pkg::ROM_DEPTH];
    longint           cos_w[lfmor_pkg::ROM_DEPTH];
    lfmor_pkg::out_t  pending_beats[$];
    int               errors;

    function new();
      longint unsigned x;
      longint unsigned q;
      longint unsigned r;
      longint          s0;
      longint          c0;
      regs = '{scan_length: 11'd1000, footprint_halfwidth_mm: 12'd450,
               footprint_front_mm: 12'd270, footprint_corner_offset: 10'd178,
               corridor_halfwidth_mm: 12'd450, box_depth_mm: 14'd2270,
               box_corner_offset: 10'd34, side_limit_offset: 10'd179};
      sample_pos   = 0;
      nearest_mm   = 0;
      nearest_seen = 1'b0;
      errors       = 0;
      for (int i = 0; i < lfmor_pkg::ROM_DEPTH; i++) begin
        x = (longint'(i) * lfmor_pkg::STEP_ANGLE_Q) % (64'd4 * lfmor_pkg::HALF_PI_Q);
        q = x / lfmor_pkg::HALF_PI_Q;
        if (q > 64'd3) q = 64'd3;
        r  = x - q * lfmor_pkg::HALF_PI_Q;
        s0 = round_q15(series(r, 1'b1));
        c0 = round_q15(series(r, 1'b0));
        case (q)
          64'd0: begin sin_w[i] = s0;  cos_w[i] = c0;  end
          64'd1: begin sin_w[i] = c0;  cos_w[i] = -s0; end
          64'd2: begin sin_w[i] = -s0; cos_w[i] = -c0; end
          default: begin sin_w[i] = -c0; cos_w[i] = s0; end
        endcase
      end
    endfunction

    // sin (odd) or cos series in units of 2^-28, clipped at zero
    function longint series(longint unsigned r, bit odd);
      longint unsigned term;
      longint unsigned k;
      longint          acc;
      bit              neg;
      term = odd ? r : (64'd1 << lfmor_pkg::ANG_FRAC);
      acc  = longint'(term);
      k    = odd ? 64'd1 : 64'd0;
      neg  = 1'b1;
      for (int n = 0; n < 40; n++) begin
        term = (((term * r) >> lfmor_pkg::ANG_FRAC) * r) >> lfmor_pkg::ANG_FRAC;
        term = term / ((k + 64'd1) * (k + 64'd2));
        k    = k + 64'd2;
        if (term == 64'd0) break;
        acc = neg ? acc - longint'(term) : acc + longint'(term);
        neg = !neg;
      end
      return (acc < 0) ? 64'sd0 : acc;
    endfunction

    function longint round_q15(longint v);
      return (v + (64'sd1 << (lfmor_pkg::ANG_FRAC - lfmor_pkg::TRIG_FRAC_BITS - 1)))
             >>> (lfmor_pkg::ANG_FRAC - lfmor_pkg::TRIG_FRAC_BITS);
    endfunction

    function bit under_limit(longint ld, longint w, longint limit);
      return (w >= 0) && (ld * w < (limit << lfmor_pkg::TRIG_FRAC_BITS));
    endfunction

    function void set_reg(logic [lfmor_pkg::CFG_AW-1:0] idx,
                          logic [lfmor_pkg::CFG_DW-1:0] val);
      case (idx)
        lfmor_pkg::REG_SCAN_LENGTH:    regs.scan_length             = val[10:0];
        lfmor_pkg::REG_FP_HALFWIDTH:   regs.footprint_halfwidth_mm  = val[11:0];
        lfmor_pkg::REG_FP_FRONT:       regs.footprint_front_mm      = val[11:0];
        lfmor_pkg::REG_FP_CORNER:      regs.footprint_corner_offset = val[9:0];
        lfmor_pkg::REG_CORR_HALFWIDTH: regs.corridor_halfwidth_mm   = val[11:0];
        lfmor_pkg::REG_BOX_DEPTH:      regs.box_depth_mm            = val[13:0];
        lfmor_pkg::REG_BOX_CORNER:     regs.box_corner_offset       = val[9:0];
        default:                       regs.side_limit_offset       = val[9:0];
      endcase
    endfunction

    function lfmor_pkg::out_t mask_and_range(lfmor_pkg::in_t smp);
      int unsigned      len;
      int unsigned      idx;
      int unsigned      cen;
      int unsigned      d;
      int unsigned      tod;
      bit               ok;
      bit               side;
      bit               hit;
      bit               last;
      longint           ld;
      longint           sw;
      longint           cw;
      longint           p;
      longint           filt;
      lfmor_pkg::zone_e zone;
      lfmor_pkg::out_t  res;
      len = 32'(regs.scan_length);
      if (len < lfmor_pkg::MIN_LEN) len = lfmor_pkg::MIN_LEN;
      if (len > lfmor_pkg::MAX_SAMPLES) len = lfmor_pkg::MAX_SAMPLES;
      idx = (sample_pos > len - 1) ? len - 1 : sample_pos;
      cen = len / 2;
      d   = (idx >= cen) ? idx - cen : cen - idx;
      ok  = !smp.range_invalid && smp.range_mm >= lfmor_pkg::NEAR_MM
            && smp.range_mm <= lfmor_pkg::FULL_MM;
      ld  = ok ? longint'(smp.range_mm) : longint'(lfmor_pkg::FULL_MM);
      sw  = sin_w[d];
      cw  = cos_w[d];

      filt = ld;
      if (ok) begin
        // centre sample takes the left-side footprint rule
        side = (idx < cen) ? (d > regs.footprint_corner_offset)
                           : (d >= regs.footprint_corner_offset);
        if (side ? under_limit(ld, sw, longint'(regs.footprint_halfwidth_mm))
                 : under_limit(ld, cw, longint'(regs.footprint_front_mm)))
          filt = longint'(lfmor_pkg::FULL_MM);
      end

      // centre sample counts as right side for the obstacle zones
      zone = lfmor_pkg::ZONE_NONE;
      if (idx <= cen) begin
        if (d >= regs.box_corner_offset && d <= regs.side_limit_offset)
          zone = lfmor_pkg::ZONE_CORR;
        else if (d < regs.box_corner_offset)
          zone = lfmor_pkg::ZONE_BOX;
      end else begin
        if (d <= regs.box_corner_offset) zone = lfmor_pkg::ZONE_BOX;
        else if (d <= regs.side_limit_offset) zone = lfmor_pkg::ZONE_CORR;
      end
      hit = 1'b0;
      if (zone == lfmor_pkg::ZONE_BOX)
        hit = under_limit(ld, cw, longint'(regs.box_depth_mm));
      else if (zone == lfmor_pkg::ZONE_CORR)
        hit = under_limit(ld, sw, longint'(regs.corridor_halfwidth_mm));
      if (hit) begin
        p   = ld * cw;
        tod = (p <= 0) ? 0 : 32'((p >>> lfmor_pkg::TRIG_FRAC_BITS) & 64'sh7FFF);
        if (!nearest_seen || tod < nearest_mm) begin
          nearest_mm   = tod;
          nearest_seen = 1'b1;
        end
      end

      last = (idx >= len - 1);
      res.filtered_range_mm = filt[14:0];
      res.scan_end          = last;
      res.obstacle_dist_mm  = '0;
      res.obstacle_found    = 1'b0;
      if (last) begin
        res.obstacle_dist_mm = nearest_seen ? 16'(nearest_mm - lfmor_pkg::LASER_OFS_MM)
                                            : 16'(lfmor_pkg::NONE_MM);
        res.obstacle_found   = nearest_seen;
        sample_pos   = 0;
        nearest_mm   = 0;
        nearest_seen = 1'b0;
      end else begin
        sample_pos = idx + 1;
      end
      return res;
    endfunction

    function void note_sample(lfmor_pkg::in_t smp);
      pending_beats.push_back(mask_and_range(smp));
    endfunction

    function void check_beat(lfmor_pkg::out_t got);
      lfmor_pkg::out_t want;
      if (pending_beats.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      want = pending_beats.pop_front();
      if (got.filtered_range_mm !== want.filtered_range_mm) begin
        $error("filtered_range_mm: expected %0d, got %0d",
               want.filtered_range_mm, got.filtered_range_mm);
        errors++;
      end
      if (got.scan_end !== want.scan_end) begin
        $error("scan_end: expected %0d, got %0d", want.scan_end, got.scan_end);
        errors++;
      end
      if (got.obstacle_dist_mm !== want.obstacle_dist_mm) begin
        $error("obstacle_dist_mm: expected %0d, got %0d",
               $signed(want.obstacle_dist_mm), $signed(got.obstacle_dist_mm));
        errors++;
      end
      if (got.obstacle_found !== want.obstacle_found) begin
        $error("obstacle_found: expected %0d, got %0d", want.obstacle_found, got.obstacle_found);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_we_i     = 1'b0;
  logic [lfmor_pkg::CFG_AW-1:0] cfg_addr_i   = '0;
  logic [lfmor_pkg::CFG_DW-1:0] cfg_wdata_i  = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  lfmor_pkg::in_t               in_data_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  lfmor_pkg::out_t              out_data_o;

  scan_scoreboard sb = new();
  int in_mode  = IDLE_RANDOM;
  int out_mode = IDLE_RANDOM;

  lidar_footprint_mask_obstacle_range_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // full random idling, none, or occasional
  function automatic int draw_gap(int mode);
    case (mode)
      IDLE_RANDOM: return $urandom_range(0, 16);
      IDLE_NONE:   return 0;
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic lfmor_pkg::in_t rand_sample();
    lfmor_pkg::in_t smp;
    smp.range_invalid = 1'b0;
    case ($urandom_range(0, 9))
      0: begin
        smp.range_mm      = 16'($urandom);
        smp.range_invalid = 1'b1;
      end
      1: smp.range_mm = 16'($urandom);
      2: smp.range_mm = 16'($urandom_range(0, 60));
      3: smp.range_mm = 16'($urandom_range(24990, 25010));
      4: smp.range_mm = 16'($urandom_range(50, 25000));
      default: smp.range_mm = 16'($urandom_range(50, 3000));
    endcase
    return smp;
  endfunction

  function automatic lfmor_pkg::cfg_t rand_cfg(bit long_scan);
    lfmor_pkg::cfg_t c;
    c.scan_length             = long_scan ? 11'($urandom_range(0, 2047))
                                          : 11'($urandom_range(2, 64));
    c.footprint_halfwidth_mm  = 12'($urandom_range(0, 4095));
    c.footprint_front_mm      = 12'($urandom_range(0, 4095));
    c.corridor_halfwidth_mm   = 12'($urandom_range(0, 4095));
    c.box_depth_mm            = 14'($urandom_range(0, 16383));
    c.footprint_corner_offset = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                            : 10'($urandom_range(0, 40));
    c.box_corner_offset       = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                            : 10'($urandom_range(0, 40));
    c.side_limit_offset       = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                            : 10'($urandom_range(0, 40));
    return c;
  endfunction

  task automatic write_reg(logic [lfmor_pkg::CFG_AW-1:0] idx,
                           logic [lfmor_pkg::CFG_DW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // waits for the block to drain, then loads a full register set
  task automatic apply_cfg(lfmor_pkg::cfg_t c);
    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(lfmor_pkg::REG_SCAN_LENGTH,    lfmor_pkg::CFG_DW'(c.scan_length));
    write_reg(lfmor_pkg::REG_FP_HALFWIDTH,   lfmor_pkg::CFG_DW'(c.footprint_halfwidth_mm));
    write_reg(lfmor_pkg::REG_FP_FRONT,       lfmor_pkg::CFG_DW'(c.footprint_front_mm));
    write_reg(lfmor_pkg::REG_FP_CORNER,      lfmor_pkg::CFG_DW'(c.footprint_corner_offset));
    write_reg(lfmor_pkg::REG_CORR_HALFWIDTH, lfmor_pkg::CFG_DW'(c.corridor_halfwidth_mm));
    write_reg(lfmor_pkg::REG_BOX_DEPTH,      lfmor_pkg::CFG_DW'(c.box_depth_mm));
    write_reg(lfmor_pkg::REG_BOX_CORNER,     lfmor_pkg::CFG_DW'(c.box_corner_offset));
    write_reg(lfmor_pkg::REG_SIDE_LIMIT,     lfmor_pkg::CFG_DW'(c.side_limit_offset));
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(lfmor_pkg::in_t smp, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(smp);
  endtask

  task automatic push_range(int unsigned mm, bit inv);
    lfmor_pkg::in_t smp;
    smp.range_mm      = 16'(mm);
    smp.range_invalid = inv;
    push_sample(smp, draw_gap(IDLE_RANDOM));
  endtask

  // result side: random stalls, one beat checked per handshake
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = draw_gap(out_mode);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_beat(out_data_o);
    end
  end

  initial begin
    lfmor_pkg::cfg_t c;
    int              sent;
    int              ph;
    int              n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: six-sample scans with tight zones, range extremes and invalid flags
    c = '{scan_length: 11'd6, footprint_halfwidth_mm: 12'd450, footprint_front_mm: 12'd270,
          footprint_corner_offset: 10'd1, corridor_halfwidth_mm: 12'd450,
          box_depth_mm: 14'd2270, box_corner_offset: 10'd1, side_limit_offset: 10'd2};
    apply_cfg(c);
    push_range(0, 0);
    push_range(49, 0);
    push_range(50, 0);
    push_range(50, 0);
    push_range(25000, 0);
    push_range(25001, 0);
    push_range(100, 1);
    push_range(65535, 1);
    push_range(1, 0);
    push_range(30000, 0);
    push_range(16'h5555, 0);
    push_range(16'hAAAA, 0);
    push_range(65535, 0);
    push_range(300, 0);
    push_range(2000, 0);
    in_valid_i <= 1'b0;
    // shorten the scan mid-way: index past the end becomes the last sample
    c.scan_length             = 11'd2;
    c.footprint_corner_offset = 10'd0;
    c.box_corner_offset       = 10'd0;
    apply_cfg(c);
    push_range(400, 0);
    push_range(60, 0);
    push_range(25000, 1);
    in_valid_i <= 1'b0;
    c.scan_length = 11'd0;
    apply_cfg(c);
    push_range(80, 0);
    push_range(25000, 0);
    push_range(51, 0);
    in_valid_i <= 1'b0;

    sent = 0;
    ph   = 0;
    while (sent < 2000) begin
      case (ph)
        0: begin
          // default geometry, offsets beyond a short scan
          c = '{scan_length: 11'd40, footprint_halfwidth_mm: 12'd450,
                footprint_front_mm: 12'd270, footprint_corner_offset: 10'd178,
                corridor_halfwidth_mm: 12'd450, box_depth_mm: 14'd2270,
                box_corner_offset: 10'd34, side_limit_offset: 10'd179};
          n = 100;
        end
        1: begin
          c = '{scan_length: '1, footprint_halfwidth_mm: '1, footprint_front_mm: '1,
                footprint_corner_offset: '1, corridor_halfwidth_mm: '1, box_depth_mm: '1,
                box_corner_offset: '1, side_limit_offset: '1};
          n = 300;
        end
        2: begin
          c = '0;
          n = 60;
        end
        3: begin
          // wide corridor past 90 degrees: negative projections
          c = rand_cfg(1'b0);
          c.scan_length           = 11'd600;
          c.corridor_halfwidth_mm = '1;
          c.box_depth_mm          = '1;
          c.box_corner_offset     = '0;
          c.side_limit_offset     = '1;
          n = 620;
        end
        default: begin
          c = rand_cfg(ph % 4 == 0);
          n = 100;
        end
      endcase
      apply_cfg(c);
      in_mode  = ph % 3;
      out_mode = (ph + 1) % 3;
      repeat (n) push_sample(rand_sample(), draw_gap(in_mode));
      in_valid_i <= 1'b0;
      sent += n;
      ph++;
    end

    while (sb.pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
sv/lfmor_pkg.sv
sv/lfmor_front.sv
sv/lfmor_queue.sv
sv/lfmor_back.sv
sv/lidar_footprint_mask_obstacle_range_unit.sv
verif/tb.sv
